@@ hw/rtl/plr_pkg.sv @@
// Shared widths, defaults and codes for the parametric line rasterizer.
package plr_pkg;

  // Field widths fixed by the item format.
  localparam int CoordW = 13;  // endpoint coordinate, signed
  localparam int DeltaW = 14;  // endpoint difference, signed
  localparam int ColorW = 32;  // pixel color
  localparam int PixW   = 10;  // emitted column and row
  localparam int CrdW   = 16;  // full signed point coordinate on the line

  // Length computation: dx*dx + dy*dy, then sqrt of that value in Q.8.
  localparam int SqW   = 28;   // holds 2 * 8191^2
  localparam int RootW = 22;   // sqrt(SqW bits << 16)

  // Parameter defaults.
  localparam int SCREEN_WIDTH_DEF    = 1024;
  localparam int SCREEN_HEIGHT_DEF   = 1024;
  localparam int T_FRACTION_BITS_DEF = 16;

  typedef enum logic {
    OP_START = 1'b0,
    OP_TICK  = 1'b1
  } op_t;

endpackage

@@ hw/rtl/plr_step_unit.sv @@
// Step unit: integer square root and restoring divide over one shared subtractor.
module plr_step_unit #(
  parameter int TFracBits = plr_pkg::T_FRACTION_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [plr_pkg::SqW-1:0]       sq,
  output logic                          done,
  output logic [TFracBits:0]            step
);

  localparam int RootW   = plr_pkg::RootW;
  localparam int RemW    = RootW + 2;
  localparam int NumW    = TFracBits + 9;
  localparam int StepW   = TFracBits + 1;
  localparam int IterMax = (RootW > NumW) ? RootW : NumW;
  localparam int CntW    = $clog2(IterMax + 1);
  localparam logic [StepW-1:0] StepMax = '1;

  typedef enum logic [1:0] {
    P_IDLE,
    P_ROOT,
    P_DIV
  } phase_t;

  phase_t              phase;
  logic [2*RootW-1:0]  vsh;
  logic [RemW-1:0]     rem;
  logic [RootW-1:0]    root;
  logic [NumW-1:0]     quo;
  logic [CntW-1:0]     cnt;

  logic [RemW-1:0]     sub_a;
  logic [RemW-1:0]     sub_b;
  logic [RemW:0]       diff;
  logic                ge;
  logic                nbit;

  // Numerator is a single one in its top bit: feed it on the first divide step.
  assign nbit = (cnt == CntW'(NumW));

  // Shared compare and subtract.
  always_comb begin
    unique case (phase)
      P_ROOT: begin
        sub_a = {rem[RemW-3:0], vsh[2*RootW-1 -: 2]};
        sub_b = {1'b0, root[RootW-2:0], 2'b01};
      end
      P_DIV: begin
        sub_a = {rem[RemW-2:0], nbit};
        sub_b = {2'b00, root};
      end
      default: begin
        sub_a = '0;
        sub_b = '0;
      end
    endcase
  end

  assign diff = {1'b0, sub_a} - {1'b0, sub_b};
  assign ge   = ~diff[RemW];

  // Zero length or an oversized quotient take the largest step.
  assign step = ((root == '0) || (quo > NumW'(StepMax))) ? StepMax : quo[StepW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= P_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (phase)
        P_IDLE: begin
          if (start) begin
            vsh   <= {sq, {(2*RootW-plr_pkg::SqW){1'b0}}};
            rem   <= '0;
            root  <= '0;
            quo   <= '0;
            cnt   <= CntW'(RootW);
            phase <= P_ROOT;
          end
        end
        P_ROOT: begin
          vsh  <= {vsh[2*RootW-3:0], 2'b00};
          rem  <= ge ? diff[RemW-1:0] : sub_a;
          root <= {root[RootW-2:0], ge};
          cnt  <= cnt - 1'b1;
          if (cnt == CntW'(1)) begin
            rem   <= '0;
            cnt   <= CntW'(NumW);
            phase <= P_DIV;
          end
        end
        P_DIV: begin
          rem <= ge ? diff[RemW-1:0] : sub_a;
          quo <= {quo[NumW-2:0], ge};
          cnt <= cnt - 1'b1;
          if (cnt == CntW'(1)) begin
            done  <= 1'b1;
            phase <= P_IDLE;
          end
        end
        default: begin
          phase <= P_IDLE;
        end
      endcase
    end
  end

endmodule

@@ hw/rtl/parametric_line_rasterizer_unit.sv @@
// Top level of the parametric line rasterizer: sequencer, shared multiplier, output word.
//
// A start word latches two endpoints and a color, forms the line length in Q.8
// (sqrt of dx*dx + dy*dy) and a parameter step of one over that length in
// Q.T_FRACTION_BITS; each tick word then returns one point floor(a + t*(b-a)),
// flagged draw only inside the SCREEN_WIDTH x SCREEN_HEIGHT window, and steps
// t until it passes 1.0. Every input word yields exactly one output word. A
// start word runs the multiplier for the squares in S_SQX and S_SQY, sums them
// in S_SQSUM, then takes 22 square root steps and T_FRACTION_BITS + 9 divide
// steps in the step unit, which shares one subtractor between both, before
// S_STEP hands the step back. A tick on an active line runs S_TX, S_TY and
// S_TFIN, as the single multiplier forms t*dx and then t*dy. A tick with no
// line active answers straight from idle with done_res set. in_ready is high
// only while the sequencer is idle and the output register is free or being
// emptied.
module parametric_line_rasterizer_unit #(
  parameter int SCREEN_WIDTH    = plr_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT   = plr_pkg::SCREEN_HEIGHT_DEF,
  parameter int T_FRACTION_BITS = plr_pkg::T_FRACTION_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              op,
  input  logic signed [plr_pkg::CoordW-1:0] start_x,
  input  logic signed [plr_pkg::CoordW-1:0] start_y,
  input  logic signed [plr_pkg::CoordW-1:0] end_x,
  input  logic signed [plr_pkg::CoordW-1:0] end_y,
  input  logic [plr_pkg::ColorW-1:0]        line_color,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [plr_pkg::PixW-1:0]          pixel_x,
  output logic [plr_pkg::PixW-1:0]          pixel_y,
  output logic [plr_pkg::ColorW-1:0]        pixel_color,
  output logic                              draw,
  output logic                              done_res
);

  localparam int F      = T_FRACTION_BITS;
  localparam int CoordW = plr_pkg::CoordW;
  localparam int DeltaW = plr_pkg::DeltaW;
  localparam int CrdW   = plr_pkg::CrdW;
  localparam int PixW   = plr_pkg::PixW;
  localparam int SqW    = plr_pkg::SqW;
  localparam int TW     = F + 2;                          // t holds up to 1.0 + step
  localparam int MulW   = (F + 3 > 15) ? F + 3 : 15;      // signed multiplier operand
  localparam int PW     = MulW + DeltaW;                  // product width
  localparam int AccW   = F + CrdW;                       // origin*2^F + t*delta
  localparam logic [TW-1:0] TOne = TW'(1) << F;
  localparam logic signed [CrdW-1:0] ScrW = CrdW'(SCREEN_WIDTH);
  localparam logic signed [CrdW-1:0] ScrH = CrdW'(SCREEN_HEIGHT);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SQX,
    S_SQY,
    S_SQSUM,
    S_STEP,
    S_TX,
    S_TY,
    S_TFIN
  } state_t;

  state_t                    state;

  // Line state.
  logic signed [CoordW-1:0]  origin_x;
  logic signed [CoordW-1:0]  origin_y;
  logic signed [DeltaW-1:0]  delta_x;
  logic signed [DeltaW-1:0]  delta_y;
  logic [plr_pkg::ColorW-1:0] held_color;
  logic [TW-1:0]             param_t;
  logic [F:0]                param_step;
  logic                      line_active;

  // Working registers.
  logic [SqW-1:0]            sq;
  logic signed [PW-1:0]      prod;
  logic signed [CrdW-1:0]    x_coord;

  logic signed [MulW-1:0]    mul_a;
  logic signed [DeltaW-1:0]  mul_b;
  logic signed [CoordW-1:0]  org_sel;
  logic signed [AccW-1:0]    org_ext;
  logic signed [AccW-1:0]    acc;
  logic signed [CrdW-1:0]    coord;
  logic [TW-1:0]             t_sum;
  logic                      x_in;
  logic                      y_in;
  logic                      accept;
  logic                      step_start;
  logic                      step_done;
  logic [F:0]                step_val;
  logic [SqW-1:0]            sq_sum;

  assign in_ready = (state == S_IDLE) && (!out_valid || out_ready);
  assign accept   = in_valid && in_ready;

  // Feed the one multiplier: squares during start, t times delta during a tick.
  always_comb begin
    unique case (state)
      S_SQX: begin
        mul_a = {{(MulW-DeltaW){delta_x[DeltaW-1]}}, delta_x};
        mul_b = delta_x;
      end
      S_SQY: begin
        mul_a = {{(MulW-DeltaW){delta_y[DeltaW-1]}}, delta_y};
        mul_b = delta_y;
      end
      S_TX: begin
        mul_a = {{(MulW-TW){1'b0}}, param_t};
        mul_b = delta_x;
      end
      S_TY: begin
        mul_a = {{(MulW-TW){1'b0}}, param_t};
        mul_b = delta_y;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Point on one axis: arithmetic shift floors toward minus infinity.
  assign org_sel = (state == S_TFIN) ? origin_y : origin_x;
  assign org_ext = {{(CrdW-CoordW){org_sel[CoordW-1]}}, org_sel, {F{1'b0}}};
  assign acc     = org_ext + prod[AccW-1:0];
  assign coord   = acc[AccW-1:F];

  assign x_in  = (x_coord >= 0) && (x_coord < ScrW);
  assign y_in  = (coord >= 0) && (coord < ScrH);
  assign t_sum = param_t + TW'(param_step);

  assign sq_sum     = sq + prod[SqW-1:0];
  assign step_start = (state == S_SQSUM);

  plr_step_unit #(
    .TFracBits (F)
  ) u_step (
    .clk   (clk),
    .rst   (rst),
    .start (step_start),
    .sq    (sq_sum),
    .done  (step_done),
    .step  (step_val)
  );

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    if (rst) begin
      state       <= S_IDLE;
      out_valid   <= 1'b0;
      line_active <= 1'b0;
      origin_x    <= '0;
      origin_y    <= '0;
      delta_x     <= '0;
      delta_y     <= '0;
      held_color  <= '0;
      param_t     <= '0;
      param_step  <= '0;
    end else begin
      // Drop the output word once it is taken.
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (op == plr_pkg::OP_START) begin
              // Latch the new line; any active line is dropped.
              origin_x    <= start_x;
              origin_y    <= start_y;
              delta_x     <= DeltaW'(end_x) - DeltaW'(start_x);
              delta_y     <= DeltaW'(end_y) - DeltaW'(start_y);
              held_color  <= line_color;
              param_t     <= '0;
              line_active <= 1'b1;
              state       <= S_SQX;
            end else if (!line_active) begin
              // Tick with no line: answer at once.
              out_valid   <= 1'b1;
              pixel_x     <= '0;
              pixel_y     <= '0;
              pixel_color <= '0;
              draw        <= 1'b0;
              done_res    <= 1'b1;
            end else begin
              state <= S_TX;
            end
          end
        end
        S_SQX: begin
          state <= S_SQY;
        end
        S_SQY: begin
          // prod holds dx*dx here.
          sq    <= prod[SqW-1:0];
          state <= S_SQSUM;
        end
        S_SQSUM: begin
          state <= S_STEP;
        end
        S_STEP: begin
          if (step_done) begin
            param_step  <= step_val;
            out_valid   <= 1'b1;
            pixel_x     <= '0;
            pixel_y     <= '0;
            pixel_color <= '0;
            draw        <= 1'b0;
            done_res    <= 1'b0;
            state       <= S_IDLE;
          end
        end
        S_TX: begin
          state <= S_TY;
        end
        S_TY: begin
          // prod holds t*dx here.
          x_coord <= coord;
          state   <= S_TFIN;
        end
        S_TFIN: begin
          out_valid   <= 1'b1;
          pixel_color <= held_color;
          draw        <= x_in && y_in;
          pixel_x     <= (x_in && y_in) ? x_coord[PixW-1:0] : '0;
          pixel_y     <= (x_in && y_in) ? coord[PixW-1:0] : '0;
          // Advance t; past 1.0 the line is finished.
          if (t_sum > TOne) begin
            param_t     <= '0;
            line_active <= 1'b0;
            done_res    <= 1'b1;
          end else begin
            param_t  <= t_sum;
            done_res <= 1'b0;
          end
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // The step unit only finishes while the sequencer waits for it.
  a_step_done_waits: assert property (@(posedge clk) disable iff (rst)
    step_done |-> state == S_STEP)
    else $error("step unit finished outside the wait state");

  // A tick on an active line returns its word once S_TX, S_TY and S_TFIN have run.
  a_tick_latency: assert property (@(posedge clk) disable iff (rst)
    (accept && op == plr_pkg::OP_TICK && line_active) |-> ##4 out_valid)
    else $error("tick word not produced on time");

  // No new word is taken while a result is stalled.
  a_no_accept_on_stall: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !in_ready)
    else $error("input taken while output stalled");

  // A point not drawn carries zero coordinates.
  a_undrawn_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !draw) |-> (pixel_x == '0 && pixel_y == '0))
    else $error("undrawn point carries coordinates");
`endif

endmodule

@@ tb/parametric_line_rasterizer_unit_test.sv @@
// Self-checking testbench for the parametric line rasterizer: scoreboard, drivers, checks.
`timescale 1ns / 100ps

module parametric_line_rasterizer_unit_test;

  localparam int TFRAC = plr_pkg::T_FRACTION_BITS_DEF;
  localparam int SCR_W = plr_pkg::SCREEN_WIDTH_DEF;
  localparam int SCR_H = plr_pkg::SCREEN_HEIGHT_DEF;
  localparam longint unsigned T_ONE = 64'd1 << TFRAC;
  localparam longint unsigned STEP_TOP = (64'd1 << (TFRAC + 1)) - 1;
  localparam int CYCLE_LIMIT = 500_000;
  localparam int HOLD_CYCLES = 300;   // length of the long receiver hold-off
  localparam int DRAIN_CYCLES = 64;   // covers the start word's sqrt/divide latency

  // One output word as the block should return it.
  typedef struct packed {
    logic [plr_pkg::PixW-1:0]   px;
    logic [plr_pkg::PixW-1:0]   py;
    logic [plr_pkg::ColorW-1:0] color;
    logic                       draw;
    logic                       done;
  } pixel_word_t;

  // Predicts the pixel stream and holds the pixel words still to come.
  class pixel_scoreboard;
    logic signed [plr_pkg::CoordW-1:0] org_x, org_y;
    logic signed [plr_pkg::DeltaW-1:0] dlt_x, dlt_y;
    logic [plr_pkg::ColorW-1:0]        line_rgb;
    longint unsigned                   t_acc, t_inc;
    bit                                line_on;
    pixel_word_t                       expected_q[$];
    int                                mismatches;
    int                                words_seen;

    function new();
      org_x = '0; org_y = '0; dlt_x = '0; dlt_y = '0;
      line_rgb = '0; t_acc = 0; t_inc = 0; line_on = 0;
      mismatches = 0; words_seen = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function longint unsigned root_floor(longint unsigned v);
      longint unsigned r = 0;
      longint unsigned trial;
      for (int b = 31; b >= 0; b--) begin
        trial = r | (64'd1 << b);
        if (trial * trial <= v) r = trial;
      end
      return r;
    endfunction

    // floor(origin + t * delta) with t in Q.TFRAC; arithmetic shift floors.
    function longint line_point(logic signed [plr_pkg::CoordW-1:0] o,
                                logic signed [plr_pkg::DeltaW-1:0] d,
                                longint unsigned t);
      longint acc;
      acc = longint'(o) * longint'(T_ONE) + longint'(t) * longint'(d);
      return acc >>> TFRAC;
    endfunction

    function void note_input(plr_pkg::op_t code,
                             logic signed [plr_pkg::CoordW-1:0] ax, ay, bx, by,
                             logic [plr_pkg::ColorW-1:0] c);
      pixel_word_t w;
      longint dx, dy, px_full, py_full;
      longint unsigned len8, q;
      w = '0;
      if (code == plr_pkg::OP_START) begin
        // Latch the line and form the step as one over the Q.8 length.
        dx = longint'(bx) - longint'(ax);
        dy = longint'(by) - longint'(ay);
        len8 = root_floor(longint'(dx * dx + dy * dy) << 16);
        org_x = ax;
        org_y = ay;
        dlt_x = dx[plr_pkg::DeltaW-1:0];
        dlt_y = dy[plr_pkg::DeltaW-1:0];
        line_rgb = c;
        t_acc = 0;
        if (len8 == 0) begin
          t_inc = STEP_TOP;
        end else begin
          q = (64'd1 << (TFRAC + 8)) / len8;
          t_inc = (q > STEP_TOP) ? STEP_TOP : q;
        end
        line_on = 1;
      end else if (!line_on) begin
        w.done = 1'b1;
      end else begin
        px_full = line_point(org_x, dlt_x, t_acc);
        py_full = line_point(org_y, dlt_y, t_acc);
        w.color = line_rgb;
        if (px_full >= 0 && px_full < SCR_W && py_full >= 0 && py_full < SCR_H) begin
          w.draw = 1'b1;
          w.px = px_full[plr_pkg::PixW-1:0];
          w.py = py_full[plr_pkg::PixW-1:0];
        end
        t_acc += t_inc;
        if (t_acc > T_ONE) begin
          line_on = 0;
          t_acc = 0;
          w.done = 1'b1;
        end
      end
      expected_q.push_back(w);
    endfunction

    function void check_result(logic [plr_pkg::PixW-1:0] px, py,
                               logic [plr_pkg::ColorW-1:0] pc,
                               logic dr, dn);
      pixel_word_t want;
      words_seen++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("output word %0d arrived with none outstanding: x=%0d y=%0d color=%h",
                   words_seen, px, py, pc);
        return;
      end
      want = expected_q.pop_front();
      if (want.px !== px || want.py !== py || want.color !== pc ||
          want.draw !== dr || want.done !== dn) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"word %0d mismatch: expected x=%0d y=%0d color=%h draw=%b done=%b\n",
                    "                   got      x=%0d y=%0d color=%h draw=%b done=%b"},
                   words_seen, want.px, want.py, want.color, want.draw, want.done,
                   px, py, pc, dr, dn);
      end
    endfunction
  endclass

  logic                              clk;
  logic                              rst;
  logic                              in_valid;
  logic                              in_ready;
  plr_pkg::op_t                      op;
  logic signed [plr_pkg::CoordW-1:0] start_x, start_y, end_x, end_y;
  logic [plr_pkg::ColorW-1:0]        line_color;
  logic                              out_valid;
  logic                              out_ready;
  logic [plr_pkg::PixW-1:0]          pixel_x, pixel_y;
  logic [plr_pkg::ColorW-1:0]        pixel_color;
  logic                              draw;
  logic                              done_res;

  pixel_scoreboard sb;
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  logic hold_off = 1'b0;
  logic pressure_go = 1'b0;
  int   cycles = 0;

  parametric_line_rasterizer_unit #(
    .SCREEN_WIDTH   (SCR_W),
    .SCREEN_HEIGHT  (SCR_H),
    .T_FRACTION_BITS(TFRAC)
  ) uut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .op         (op),
    .start_x    (start_x),
    .start_y    (start_y),
    .end_x      (end_x),
    .end_y      (end_y),
    .line_color (line_color),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .pixel_x    (pixel_x),
    .pixel_y    (pixel_y),
    .pixel_color(pixel_color),
    .draw       (draw),
    .done_res   (done_res)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Bound the run; a hang or a lost word ends here.
  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("FAIL");
    $finish;
  end

  // Receiver: stall at the phase rate, hold off fully while a pressure window runs.
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off) begin
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Long hold-off counted here so the sender keeps offering words meanwhile
  // and the block backs up into its input.
  initial begin
    wait (pressure_go);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  // Check every output word taken at an edge, using pre-edge values.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_result(pixel_x, pixel_y, pixel_color, draw, done_res);
  end

  function automatic logic signed [plr_pkg::CoordW-1:0] rand_coord();
    logic [31:0] r;
    r = $urandom();
    return r[plr_pkg::CoordW-1:0];
  endfunction

  function automatic logic signed [plr_pkg::CoordW-1:0] to_coord(int v);
    return v[plr_pkg::CoordW-1:0];
  endfunction

  // Offer one input word and hold it until taken. Drop valid only when
  // an idle gap is taken, so valid never toggles twice in one step.
  task automatic send_word(input plr_pkg::op_t code,
                           input logic signed [plr_pkg::CoordW-1:0] ax, ay, bx, by,
                           input logic [plr_pkg::ColorW-1:0] c);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    op         <= code;
    start_x    <= ax;
    start_y    <= ay;
    end_x      <= bx;
    end_y      <= by;
    line_color <= c;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_input(code, ax, ay, bx, by, c);
  endtask

  // Ticks carry junk endpoints; the block must ignore them.
  task automatic send_tick();
    send_word(plr_pkg::OP_TICK, rand_coord(), rand_coord(), rand_coord(), rand_coord(),
              $urandom());
  endtask

  // Start a line and walk it until it finishes or the tick budget runs out.
  task automatic trace_line(input int ax, ay, bx, by, input logic [plr_pkg::ColorW-1:0] c,
                            input int max_ticks);
    int n = 0;
    send_word(plr_pkg::OP_START, to_coord(ax), to_coord(ay), to_coord(bx), to_coord(by), c);
    while (sb.line_on && n < max_ticks) begin
      send_tick();
      n++;
    end
  endtask

  // Mostly short lines around the window so edges get crossed often,
  // some medium ones, some zero length, some anywhere in range.
  task automatic pick_line(output logic signed [plr_pkg::CoordW-1:0] ax, ay, bx, by);
    int kind, x0, y0, span;
    kind = $urandom_range(99);
    x0 = int'($urandom_range(1103)) - 40;
    y0 = int'($urandom_range(1103)) - 40;
    span = (kind < 75) ? 24 : 300;
    ax = to_coord(x0);
    ay = to_coord(y0);
    bx = to_coord(x0 + int'($urandom_range(2 * span)) - span);
    by = to_coord(y0 + int'($urandom_range(2 * span)) - span);
    if (kind >= 85 && kind < 93) begin
      bx = ax;
      by = ay;
    end else if (kind >= 93) begin
      ax = rand_coord();
      ay = rand_coord();
      bx = rand_coord();
      by = rand_coord();
    end
  endtask

  // Mostly whole lines walked to the end; now and then cut a line short
  // with a new start, or tick with no line active.
  task automatic random_run(input int count);
    int sent = 0;
    int ticks = 0;
    int cap = 0;
    int pick;
    logic signed [plr_pkg::CoordW-1:0] ax, ay, bx, by;
    while (sent < count) begin
      pick = $urandom_range(99);
      if (sb.line_on && ticks < cap && pick >= 4) begin
        send_tick();
        ticks++;
      end else if (!sb.line_on && pick < 12) begin
        send_tick();
      end else begin
        pick_line(ax, ay, bx, by);
        send_word(plr_pkg::OP_START, ax, ay, bx, by, $urandom());
        ticks = 0;
        cap = ($urandom_range(9) == 0) ? int'($urandom_range(1, 8)) : 80;
      end
      sent++;
    end
  endtask

  initial begin
    sb = new();
    rst        <= 1'b1;
    in_valid   <= 1'b0;
    op         <= plr_pkg::OP_START;
    start_x    <= '0;
    start_y    <= '0;
    end_x      <= '0;
    end_y      <= '0;
    line_color <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed words, no idling.
    send_tick();                                               // tick with no line
    trace_line(5, 5, 5, 5, 32'h1234_5678, 4);                  // zero length: one point
    send_tick();
    trace_line(-4096, -4096, 4095, 4095, 32'hFFFF_FFFF, 2);    // extremes, far outside
    trace_line(4095, -4096, -4096, 4095, 32'h0000_0000, 1);    // drops the previous line
    trace_line(-2, 1021, 3, 1026, 32'hA5A5_5A5A, 20);          // crosses left and bottom edges
    trace_line(0, 0, 1, 0, 32'h0000_00FF, 4);                  // unit length: two points

    // Random phases; the pressure window lands in the first one.
    pressure_go <= 1'b1;
    random_run(350);
    send_idle_pct = 72;
    recv_stall_pct <= 0;
    random_run(350);
    send_idle_pct = 0;
    recv_stall_pct <= 72;
    random_run(350);
    send_idle_pct = 25;
    recv_stall_pct <= 25;
    random_run(350);
    in_valid <= 1'b0;

    // Drain, then give a late extra word time to show up.
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/plr_pkg.sv
hw/rtl/plr_step_unit.sv
hw/rtl/parametric_line_rasterizer_unit.sv
tb/parametric_line_rasterizer_unit_test.sv
